// File: sv/ising_metropolis_spin_update_assert.svh
// ----------------------------------------------------------------------------
// ising metropolis spin update: assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ISING_METROPOLIS_SPIN_UPDATE_ASSERT_SVH
`define ISING_METROPOLIS_SPIN_UPDATE_ASSERT_SVH

// same-cycle implication
`define ISMU_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ismu same-cycle check failed");

// next-cycle implication
`define ISMU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ismu next-cycle check failed");

`endif

// File: sv/ismu_pkg.sv
// ----------------------------------------------------------------------------
// ismu_pkg
// Widths, reset values, register indexes and shared types of the spin update.
// ----------------------------------------------------------------------------
package ismu_pkg;

  // lattice size default
  localparam int unsigned GRID_SIZE_DEF = 64;

  // field widths
  localparam int unsigned IDX_IN_W   = 6;
  localparam int unsigned ROW_W      = IDX_IN_W;
  localparam int unsigned COL_W      = IDX_IN_W;
  localparam int unsigned RAND_W     = 32;
  localparam int unsigned THR_W      = 32;
  localparam int unsigned MAG_W      = 14;
  localparam int unsigned EN_W       = 16;
  localparam int unsigned MAG_DW     = 3;
  localparam int unsigned EN_DW      = 6;
  localparam int unsigned NBR_CNT_W  = 3;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_TWO  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THR_FOUR = 1'd1;

  // threshold reset values
  localparam logic [THR_W-1:0] THR_TWO_RST  = 32'd1930017468;
  localparam logic [THR_W-1:0] THR_FOUR_RST = 32'd867263635;

  // control states
  typedef enum logic {
    ST_CLEAR,
    ST_RUN
  } ismu_state_e;

  // flip decision handed from the decision logic to the datapath
  typedef struct packed {
    logic                     flip;
    logic                     new_spin;
    logic signed [MAG_DW-1:0] mag_delta;
    logic signed [EN_DW-1:0]  en_delta;
  } ismu_dec_t;

endpackage

// File: sv/ismu_chan_if.sv
// ----------------------------------------------------------------------------
// ismu channel interfaces
// Valid/ready channels for site attempts and for step results.
// ----------------------------------------------------------------------------
interface ismu_in_if;
  import ismu_pkg::*;

  logic              valid;
  logic              ready;
  logic [ROW_W-1:0]  row;
  logic [COL_W-1:0]  col;
  logic [RAND_W-1:0] rand_word;

  modport source (output valid, output row, output col, output rand_word, input ready);
  modport sink   (input valid, input row, input col, input rand_word, output ready);
endinterface

interface ismu_out_if;
  import ismu_pkg::*;

  logic                    valid;
  logic                    ready;
  logic                    accepted;
  logic                    new_spin;
  logic signed [MAG_W-1:0] magnetisation_sum;
  logic signed [EN_W-1:0]  energy_sum;

  modport source (output valid, output accepted, output new_spin,
                  output magnetisation_sum, output energy_sum, input ready);
  modport sink   (input valid, input accepted, input new_spin,
                  input magnetisation_sum, input energy_sum, output ready);
endinterface

// File: sv/ismu_row_ram.sv
// ----------------------------------------------------------------------------
// ismu_row_ram
// One lattice copy, one row per word: one write port, one registered read.
// ----------------------------------------------------------------------------
module ismu_row_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read, holds while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// File: sv/ismu_flip_logic.sv
// ----------------------------------------------------------------------------
// ismu_flip_logic
// Metropolis acceptance of one site from its spin and four neighbour spins.
// ----------------------------------------------------------------------------
module ismu_flip_logic (
  input  logic                            site_i,
  input  logic [3:0]                      nbr_i,
  input  logic [ismu_pkg::RAND_W-1:0]     rand_word_i,
  input  logic [ismu_pkg::THR_W-1:0]      thr_two_i,
  input  logic [ismu_pkg::THR_W-1:0]      thr_four_i,
  output ismu_pkg::ismu_dec_t             dec_o
);
  import ismu_pkg::*;

  logic [3:0]           agree;
  logic [NBR_CNT_W-1:0] n_agree;
  logic                 flip;
  logic [EN_DW:0]       en_wide;

  // neighbours equal to the site spin; s*h = 2*n_agree - 4
  assign agree   = ~(nbr_i ^ {4{site_i}});
  assign n_agree = NBR_CNT_W'(agree[0]) + NBR_CNT_W'(agree[1])
                 + NBR_CNT_W'(agree[2]) + NBR_CNT_W'(agree[3]);

  // non-positive s*h always flips, otherwise compare against the bound
  always_comb begin
    priority if (n_agree <= NBR_CNT_W'(2)) begin
      flip = 1'b1;
    end else if (n_agree == NBR_CNT_W'(3)) begin
      flip = rand_word_i < thr_two_i;
    end else begin
      flip = rand_word_i < thr_four_i;
    end
  end

  // energy step 4*s*h = 8*n_agree - 16
  assign en_wide = (EN_DW + 1)'({n_agree, 3'b000}) - (EN_DW + 1)'(16);

  always_comb begin
    dec_o.flip      = flip;
    dec_o.new_spin  = site_i ^ flip;
    dec_o.mag_delta = '0;
    dec_o.en_delta  = '0;
    if (flip) begin
      dec_o.mag_delta = site_i ? -MAG_DW'(2) : MAG_DW'(2);
      dec_o.en_delta  = EN_DW'(en_wide);
    end
  end

endmodule

// File: sv/ising_metropolis_spin_update.sv
// ----------------------------------------------------------------------------
// ising_metropolis_spin_update
// Metropolis single-site update of a periodic square lattice of spins,
// with running magnetisation and energy sums.
//
//   channel  dir  handshake      payload
//   in_i     in   valid/ready    row, col, rand_word
//   out_o    out  valid/ready    accepted, new_spin, magnetisation_sum,
//                                energy_sum
//   cfg      in   cfg_we_i       cfg_idx_i, cfg_wdata_i
//
// One attempt per cycle sustained while out_o is not stalled: three row copies
// of the lattice are read in the accept cycle, the decision and write-back follow
// in the decision stage from the registered rows, and the result is registered
// in the output register. After reset a clearing pass writes all GRID_SIZE rows
// to +1 with in_i.ready low; config writes still apply. A stalled output holds
// one result and one attempt in flight, then ready drops.
// ----------------------------------------------------------------------------
`include "ising_metropolis_spin_update_assert.svh"

module ising_metropolis_spin_update #(
  parameter int unsigned GRID_SIZE = ismu_pkg::GRID_SIZE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ismu_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ismu_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  ismu_in_if.sink                         in_i,
  ismu_out_if.source                      out_o
);
  import ismu_pkg::*;

  localparam int unsigned IDX_W = $clog2(GRID_SIZE);
  localparam int unsigned SPAN  = 2 ** IDX_IN_W;
  localparam int          SITES = int'(GRID_SIZE * GRID_SIZE);
  localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(GRID_SIZE - 1);
  localparam logic signed [MAG_W-1:0] MAG_RST  = MAG_W'(SITES);
  localparam logic signed [EN_W-1:0]  EN_RST   = EN_W'(-4 * SITES);

  // control
  ismu_state_e         state_q, state_d;
  logic [IDX_W-1:0]    clr_row_q, clr_row_d;
  logic                clr_we;
  logic                accept;
  logic                s1_adv;

  // input side
  logic [IDX_W-1:0]    mod_tbl [SPAN];
  logic [IDX_W-1:0]    in_row, in_col, in_up, in_dn;

  // lattice copies
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic [GRID_SIZE-1:0] ram_wdata;
  logic [GRID_SIZE-1:0] rd_up, rd_mid, rd_dn;

  // decision stage
  logic                s1_vld_q;
  logic [IDX_W-1:0]    row_q, col_q, up_q, dn_q;
  logic [RAND_W-1:0]   rw_q;
  logic                fwd_vld_q;
  logic [IDX_W-1:0]    fwd_row_q;
  logic [GRID_SIZE-1:0] fwd_data_q;
  logic [GRID_SIZE-1:0] row_u, row_c, row_d, row_new, col_bit;
  logic [IDX_W-1:0]    lf, rt;
  logic [3:0]          nbr;
  ismu_dec_t           dec;
  logic                flip_we;

  // totals and thresholds
  logic signed [MAG_W-1:0] mag_q, mag_d;
  logic signed [EN_W-1:0]  en_q, en_d;
  logic [THR_W-1:0]        thr_two_q, thr_four_q;

  // output register
  logic                    out_vld_q;
  logic                    out_acc_q, out_spin_q;
  logic signed [MAG_W-1:0] out_mag_q;
  logic signed [EN_W-1:0]  out_en_q;

  // site index wrap table, built at elaboration
  for (genvar gi = 0; gi < SPAN; gi++) begin : g_mod
    assign mod_tbl[gi] = IDX_W'(gi % GRID_SIZE);
  end

  assign in_row = mod_tbl[in_i.row];
  assign in_col = mod_tbl[in_i.col];
  assign in_up  = (in_row == '0) ? LAST_IDX : in_row - IDX_W'(1);
  assign in_dn  = (in_row == LAST_IDX) ? '0 : in_row + IDX_W'(1);

  // handshakes
  assign s1_adv     = s1_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = (state_q == ST_RUN) && (!s1_vld_q || s1_adv);
  assign accept     = in_i.valid && in_i.ready;

  // clearing pass state machine
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_row_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_row_q <= clr_row_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_row_d = clr_row_q;
    clr_we    = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        clr_we    = 1'b1;
        clr_row_d = clr_row_q + IDX_W'(1);
        if (clr_row_q == LAST_IDX) begin
          state_d   = ST_RUN;
          clr_row_d = '0;
        end
      end
      ST_RUN: begin
        state_d = ST_RUN;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  // shared write port of the three copies
  assign flip_we   = s1_adv && dec.flip;
  assign ram_we    = clr_we || flip_we;
  assign ram_waddr = clr_we ? clr_row_q : row_q;
  assign ram_wdata = clr_we ? '1 : row_new;

  ismu_row_ram #(.WIDTH(GRID_SIZE), .DEPTH(GRID_SIZE)) u_ram_up (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .re_i(accept), .raddr_i(in_up), .rdata_o(rd_up)
  );

  ismu_row_ram #(.WIDTH(GRID_SIZE), .DEPTH(GRID_SIZE)) u_ram_mid (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .re_i(accept), .raddr_i(in_row), .rdata_o(rd_mid)
  );

  ismu_row_ram #(.WIDTH(GRID_SIZE), .DEPTH(GRID_SIZE)) u_ram_dn (
    .clk_i, .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(ram_wdata),
    .re_i(accept), .raddr_i(in_dn), .rdata_o(rd_dn)
  );

  // decision stage valid and bypass flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
    end else begin
      if (accept) begin
        s1_vld_q  <= 1'b1;
        fwd_vld_q <= flip_we;
      end else if (s1_adv) begin
        s1_vld_q  <= 1'b0;
      end
    end
  end

  // attempt payload and the row written in the same transfer cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      row_q      <= in_row;
      col_q      <= in_col;
      up_q       <= in_up;
      dn_q       <= in_dn;
      rw_q       <= in_i.rand_word;
      fwd_row_q  <= row_q;
      fwd_data_q <= row_new;
    end
  end

  // bypass a write that raced this attempt's read
  assign row_u = (fwd_vld_q && (fwd_row_q == up_q))  ? fwd_data_q : rd_up;
  assign row_c = (fwd_vld_q && (fwd_row_q == row_q)) ? fwd_data_q : rd_mid;
  assign row_d = (fwd_vld_q && (fwd_row_q == dn_q))  ? fwd_data_q : rd_dn;

  assign lf = (col_q == '0) ? LAST_IDX : col_q - IDX_W'(1);
  assign rt = (col_q == LAST_IDX) ? '0 : col_q + IDX_W'(1);

  assign nbr     = {row_u[col_q], row_d[col_q], row_c[lf], row_c[rt]};
  assign col_bit = {{(GRID_SIZE - 1){1'b0}}, 1'b1} << col_q;
  assign row_new = row_c ^ col_bit;

  ismu_flip_logic u_flip (
    .site_i     (row_c[col_q]),
    .nbr_i      (nbr),
    .rand_word_i(rw_q),
    .thr_two_i  (thr_two_q),
    .thr_four_i (thr_four_q),
    .dec_o      (dec)
  );

  // running sums
  assign mag_d = mag_q + MAG_W'(dec.mag_delta);
  assign en_d  = en_q + EN_W'(dec.en_delta);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q <= MAG_RST;
      en_q  <= EN_RST;
    end else if (s1_adv) begin
      mag_q <= mag_d;
      en_q  <= en_d;
    end
  end

  // threshold registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_two_q  <= THR_TWO_RST;
      thr_four_q <= THR_FOUR_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_THR_TWO) begin
        thr_two_q <= THR_W'(cfg_wdata_i);
      end
      if (cfg_idx_i == CFG_THR_FOUR) begin
        thr_four_q <= THR_W'(cfg_wdata_i);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_adv) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_acc_q  <= dec.flip;
      out_spin_q <= dec.new_spin;
      out_mag_q  <= mag_d;
      out_en_q   <= en_d;
    end
  end

  assign out_o.valid             = out_vld_q;
  assign out_o.accepted          = out_acc_q;
  assign out_o.new_spin          = out_spin_q;
  assign out_o.magnetisation_sum = out_mag_q;
  assign out_o.energy_sum        = out_en_q;

  // checks
  `ISMU_ASSERT_IMP(a_no_take_in_clear, state_q == ST_CLEAR, !in_i.ready)
  `ISMU_ASSERT_NEXT(a_clear_ends, state_q == ST_CLEAR && clr_row_q == LAST_IDX, state_q == ST_RUN)
  `ISMU_ASSERT_IMP(a_no_write_clash, flip_we, !clr_we)
  `ISMU_ASSERT_NEXT(a_flip_moves_mag, flip_we, mag_q != $past(mag_q))
  `ISMU_ASSERT_NEXT(a_hold_keeps_energy, s1_adv && !dec.flip, $stable(en_q))

endmodule
